// ===== design/tbr_pkg.sv =====
`default_nettype none
package tbr_pkg;

  // opcode values of an input request
  localparam logic OP_BOX  = 1'b0;
  localparam logic OP_PAIR = 1'b1;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int QAW     = 2;

  // saturation limits of the box fields
  localparam int POS_MAX  = 2047;
  localparam int NEG_MAG  = 2048;
  localparam int LEN_MAX  = 2047;
  localparam int LIM_SHIFT = 6;   // eight sigma squared is 64

  typedef struct packed {
    logic              opcode;
    logic signed [11:0] box_left;
    logic signed [11:0] box_top;
    logic [10:0]       box_width;
    logic [10:0]       box_height;
    logic [15:0]       before_x;
    logic [15:0]       before_y;
    logic [15:0]       after_x;
    logic [15:0]       after_y;
    logic              last_pair;
  } in_t;

  typedef struct packed {
    logic signed [11:0] new_left;
    logic signed [11:0] new_top;
    logic [10:0]       new_width;
    logic [10:0]       new_height;
    logic [8:0]        kept_count;
    logic              degenerate;
  } out_t;

  // request class decided by the front
  typedef enum logic [1:0] {
    CMD_BOX   = 2'd0,
    CMD_PAIR  = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic signed [11:0] box_left;
    logic signed [11:0] box_top;
    logic [10:0]       box_width;
    logic [10:0]       box_height;
    logic [63:0]       pair;      // {before_x, before_y, after_x, after_y}
  } cmd_t;

endpackage
`default_nettype wire

// ===== design/track_box_rescale.sv =====
// Box loads and point pairs are taken one per cycle through a 4-entry queue while it is
// not full. A closing pair of a frame starts three passes over the point memory, then a
// bit-serial multiplier and divider update the box; a degenerate frame skips both of them.
// Reset clears the queue, the pair count and the box; the point memory is not cleared.
`default_nettype none
module track_box_rescale #(
  parameter int MAX_POINTS = 256,
  parameter int FRAC_BITS  = 6
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire tbr_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output tbr_pkg::out_t      out_data
);

  logic          q_valid, q_pop;
  tbr_pkg::cmd_t q_cmd;

  // accept and classify
  tbr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd)
  );

  // frame processing
  tbr_back #(
    .MAX_POINTS (MAX_POINTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== design/tbr_front.sv =====
`default_nettype none
module tbr_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire tbr_pkg::in_t   in_data,
  output logic                q_valid,
  input  wire logic           q_pop,
  output tbr_pkg::cmd_t       q_cmd
);

  tbr_pkg::cmd_t             fifo_r [tbr_pkg::Q_DEPTH];
  logic [tbr_pkg::QAW-1:0]   wp_r, rp_r;
  logic [tbr_pkg::QAW:0]     fill_r;
  tbr_pkg::cmd_t             cls;
  logic                      push;

  // classify the incoming request
  always_comb begin
    cls.box_left   = in_data.box_left;
    cls.box_top    = in_data.box_top;
    cls.box_width  = in_data.box_width;
    cls.box_height = in_data.box_height;
    cls.pair       = {in_data.before_x, in_data.before_y, in_data.after_x, in_data.after_y};
    if (in_data.opcode == tbr_pkg::OP_BOX) begin
      cls.kind = tbr_pkg::CMD_BOX;
    end else if (in_data.last_pair) begin
      cls.kind = tbr_pkg::CMD_CLOSE;
    end else begin
      cls.kind = tbr_pkg::CMD_PAIR;
    end
  end

  assign in_stall = (fill_r == (tbr_pkg::QAW+1)'(tbr_pkg::Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill_r != '0);
  assign q_cmd    = fifo_r[rp_r];

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop && q_valid) rp_r <= rp_r + 1'b1;
      if (push && !(q_pop && q_valid)) begin
        fill_r <= fill_r + 1'b1;
      end else if (!push && q_pop && q_valid) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= cls;
  end

endmodule
`default_nettype wire

// ===== design/tbr_mul.sv =====
`default_nettype none
module tbr_mul #(
  parameter int A_W = 8,
  parameter int B_W = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output logic                    done,
  output logic [A_W+B_W-1:0]      prod
);

  localparam int P_W = A_W + B_W;
  localparam int N_W = $clog2(B_W + 1);

  logic [P_W-1:0] acc_r, ash_r;
  logic [B_W-1:0] b_r;
  logic [N_W-1:0] cnt_r;
  logic           busy_r, done_r;

  // one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= N_W'(B_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == N_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      ash_r <= P_W'(a);
      b_r   <= b;
    end else if (busy_r) begin
      if (b_r[0]) acc_r <= acc_r + ash_r;
      ash_r <= ash_r << 1;
      b_r   <= b_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

// ===== design/tbr_div.sv =====
`default_nettype none
module tbr_div #(
  parameter int W = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [W-1:0]  num,
  input  wire logic [W-1:0]  den,
  output logic               done,
  output logic [W-1:0]       quo
);

  localparam int N_W = $clog2(W + 1);

  logic [W-1:0]   rem_r, nsh_r, den_r, quo_r;
  logic [N_W-1:0] cnt_r;
  logic           busy_r, done_r;
  logic [W:0]     rem_sh;
  logic           fits;

  // restoring step, one quotient bit per cycle
  assign rem_sh = {rem_r, nsh_r[W-1]};
  assign fits   = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= N_W'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == N_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      nsh_r <= num;
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? W'(rem_sh - {1'b0, den_r}) : W'(rem_sh);
      nsh_r <= nsh_r << 1;
      quo_r <= {quo_r[W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ===== design/tbr_back.sv =====
`default_nettype none
module tbr_back #(
  parameter int MAX_POINTS = 256,
  parameter int FRAC_BITS  = 6
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  output logic                 q_pop,
  input  wire tbr_pkg::cmd_t   q_cmd,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output tbr_pkg::out_t        out_data
);

  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int AW   = $clog2(MAX_POINTS);
  localparam int SW   = 16 + CW;
  localparam int DSW  = 17 + CW;
  localparam int SQW  = 32 + CW;
  localparam int VW   = 2 * CW + 32;
  localparam int LIMW = VW + tbr_pkg::LIM_SHIFT;
  localparam int NNW  = 2 * CW;
  localparam int PXW  = 32 + NNW;
  localparam int PW   = 16 + 2 * CW;
  localparam int MSW  = CW + FRAC_BITS;
  localparam int EMW  = 13 + MSW;
  localparam int UW   = ((SW > EMW) ? SW : EMW) + 2;
  localparam int MPW  = UW + PW;
  localparam int LW   = MPW + 4;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_P1   = 9'b000000010,
    S_LIM1 = 9'b000000100,
    S_LIM2 = 9'b000001000,
    S_P2   = 9'b000010000,
    S_P3   = 9'b000100000,
    S_CHK  = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  typedef enum logic [11:0] {
    F_EM  = 12'b000000000001,
    F_U   = 12'b000000000010,
    F_T1  = 12'b000000000100,
    F_T2  = 12'b000000001000,
    F_DD  = 12'b000000010000,
    F_NUM = 12'b000000100000,
    F_N2  = 12'b000001000000,
    F_ADJ = 12'b000010000000,
    F_DPL = 12'b000100000000,
    F_LP  = 12'b001000000000,
    F_SPR = 12'b010000000000,
    F_DSC = 12'b100000000000
  } fstep_t;

  state_t st_r;
  fstep_t fs_r;
  logic   axis_r, go_r;

  // box and frame bookkeeping
  logic signed [11:0] bl_r, bt_r;
  logic [10:0]        bw_r, bh_r;
  logic [CW-1:0]      cnt_r, idx_r, m_r;
  logic               degen_r;

  // point memory and keep flags
  logic [63:0] pt_mem [MAX_POINTS];
  logic        kp_mem [MAX_POINTS];
  logic [63:0] rd_data_r;
  logic        kp_rd_r;
  logic        pt_we, kp_we, keep, issue, in_pass, drained;
  logic [AW-1:0] rd_addr;

  // pass pipeline
  logic               s1_v_r, a_v_r, b_v_r, c_v_r;
  logic [AW-1:0]      s1_addr_r, a_addr_r, b_addr_r, c_addr_r;
  logic signed [16:0] a_dx_r, a_dy_r, b_dx_r, b_dy_r;
  logic [63:0]        a_pt_r, b_pt_r, c_pt_r;
  logic               a_kp_r, b_kp_r;
  logic [31:0]        b_sqx_r, b_sqy_r;
  logic [SW-1:0]      b_mbx_r, b_mby_r, b_max_r, b_may_r;
  logic [PXW-1:0]     c_px_r, c_py_r;
  logic signed [33:0] sqx_full, sqy_full;

  // accumulators
  logic signed [DSW-1:0] sdx_r, sdy_r;
  logic [SQW-1:0]        sqx_r, sqy_r;
  logic [VW-1:0]         nsx_r, nsy_r, sdsx_r, sdsy_r;
  logic signed [2*DSW-1:0] sdsx_full, sdsy_full;
  logic [NNW-1:0]        nn_r;
  logic [LIMW-1:0]       limx_r, limy_r;
  logic [SW-1:0]         sax_r, say_r, sbx_r, sby_r;
  logic [PW-1:0]         pax_r, pay_r, pbx_r, pby_r;
  logic [SW-1:0]         dbx, dby, dax, day;

  // box update datapath
  logic [SW-1:0]          f_sb, f_sa;
  logic [PW-1:0]          f_p, f_q;
  logic signed [11:0]     f_edge;
  logic [10:0]            f_len;
  logic [MSW-1:0]         ms;
  logic signed [EMW-1:0]  em_r;
  logic signed [UW-1:0]   u_r;
  logic [UW-1:0]          u_mag;
  logic [MPW-1:0]         t1_r, t2_r, dd_r;
  logic signed [LW-1:0]   num_r, n2_r;
  logic [LW-1:0]          divn_r, divd_r;
  logic                   neg_r;
  logic                   mul_step, div_step, mul_go, div_go, mul_done, div_done;
  logic [UW-1:0]          mul_a;
  logic [PW-1:0]          mul_b;
  logic [MPW-1:0]         mul_prod;
  logic [LW-1:0]          quo;
  logic [12:0]            neg_mag;
  logic signed [11:0]     place_res;
  logic [10:0]            scale_res;

  logic           out_valid_r;
  tbr_pkg::out_t  out_data_r;
  logic           out_free;

  assign q_pop    = (st_r == S_IDLE) && q_valid;
  assign out_free = !out_valid_r || !out_stall;
  assign in_pass  = (st_r == S_P1) || (st_r == S_P2) || (st_r == S_P3);
  assign issue    = in_pass && (idx_r < cnt_r);
  assign rd_addr  = idx_r[AW-1:0];
  assign drained  = !s1_v_r && !a_v_r && !b_v_r && !c_v_r && (idx_r == cnt_r);
  assign pt_we    = q_pop && (q_cmd.kind != tbr_pkg::CMD_BOX) &&
                    (cnt_r < CW'(MAX_POINTS));
  assign keep     = !(LIMW'(c_px_r) > limx_r) && !(LIMW'(c_py_r) > limy_r);
  assign kp_we    = c_v_r && (st_r == S_P2);

  // memories, registered read
  always_ff @(posedge clk) begin
    rd_data_r <= pt_mem[rd_addr];
    kp_rd_r   <= kp_mem[rd_addr];
    if (pt_we) pt_mem[cnt_r[AW-1:0]] <= q_cmd.pair;
    if (kp_we) kp_mem[c_addr_r] <= keep;
  end

  // pass pipeline payload
  assign sqx_full  = a_dx_r * a_dx_r;
  assign sqy_full  = a_dy_r * a_dy_r;
  always_ff @(posedge clk) begin
    s1_addr_r <= rd_addr;
    a_addr_r  <= s1_addr_r;
    a_dx_r    <= $signed({1'b0, rd_data_r[31:16]}) - $signed({1'b0, rd_data_r[63:48]});
    a_dy_r    <= $signed({1'b0, rd_data_r[15:0]}) - $signed({1'b0, rd_data_r[47:32]});
    a_pt_r    <= rd_data_r;
    a_kp_r    <= kp_rd_r;
    b_addr_r  <= a_addr_r;
    b_dx_r    <= a_dx_r;
    b_dy_r    <= a_dy_r;
    b_sqx_r   <= sqx_full[31:0];
    b_sqy_r   <= sqy_full[31:0];
    b_pt_r    <= a_pt_r;
    b_kp_r    <= a_kp_r;
    b_mbx_r   <= SW'(m_r) * SW'(a_pt_r[63:48]);
    b_mby_r   <= SW'(m_r) * SW'(a_pt_r[47:32]);
    b_max_r   <= SW'(m_r) * SW'(a_pt_r[31:16]);
    b_may_r   <= SW'(m_r) * SW'(a_pt_r[15:0]);
    c_addr_r  <= b_addr_r;
    c_px_r    <= PXW'(b_sqx_r) * PXW'(nn_r);
    c_py_r    <= PXW'(b_sqy_r) * PXW'(nn_r);
    c_pt_r    <= b_pt_r;
  end

  // absolute spreads against the scaled sums
  assign dbx = (sax_r > b_mbx_r) ? sax_r - b_mbx_r : b_mbx_r - sax_r;
  assign dby = (say_r > b_mby_r) ? say_r - b_mby_r : b_mby_r - say_r;
  assign dax = (sbx_r > b_max_r) ? sbx_r - b_max_r : b_max_r - sbx_r;
  assign day = (sby_r > b_may_r) ? sby_r - b_may_r : b_may_r - sby_r;

  assign sdsx_full = sdx_r * sdx_r;
  assign sdsy_full = sdy_r * sdy_r;

  // axis selection for the box update
  assign f_sb   = axis_r ? sby_r : sbx_r;
  assign f_sa   = axis_r ? say_r : sax_r;
  assign f_p    = axis_r ? pby_r : pbx_r;
  assign f_q    = axis_r ? pay_r : pax_r;
  assign f_edge = axis_r ? bt_r : bl_r;
  assign f_len  = axis_r ? bh_r : bw_r;
  assign ms     = MSW'(m_r) << FRAC_BITS;
  assign u_mag  = u_r[UW-1] ? UW'(-u_r) : UW'(u_r);

  assign mul_step = (st_r == S_FIN) &&
                    (fs_r == F_T1 || fs_r == F_T2 || fs_r == F_DD || fs_r == F_LP);
  assign div_step = (st_r == S_FIN) && (fs_r == F_DPL || fs_r == F_DSC);
  assign mul_go   = mul_step && !go_r;
  assign div_go   = div_step && !go_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (fs_r)
      F_T1: begin mul_a = UW'(f_sb);  mul_b = f_q; end
      F_T2: begin mul_a = u_mag;      mul_b = f_p; end
      F_DD: begin mul_a = UW'(ms);    mul_b = f_q; end
      F_LP: begin mul_a = UW'(f_len); mul_b = f_p; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // saturate the quotients
  assign neg_mag   = (quo > LW'(tbr_pkg::NEG_MAG)) ? 13'(tbr_pkg::NEG_MAG) : quo[12:0];
  assign place_res = neg_r ? $signed(12'(13'd0 - neg_mag)) :
                     ((quo > LW'(tbr_pkg::POS_MAX)) ? 12'(tbr_pkg::POS_MAX) : quo[11:0]);
  assign scale_res = (quo > LW'(tbr_pkg::LEN_MAX)) ? 11'(tbr_pkg::LEN_MAX) : quo[10:0];

  tbr_mul #(.A_W(UW), .B_W(PW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  tbr_div #(.W(LW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   (divn_r),
    .den   (divd_r),
    .done  (div_done),
    .quo   (quo)
  );

  // box update datapath registers
  always_ff @(posedge clk) begin
    if (st_r == S_FIN) begin
      unique case (fs_r)
        F_EM:  em_r <= $signed(f_edge) * $signed({1'b0, ms});
        F_U:   u_r  <= $signed(UW'(f_sa)) - UW'(em_r);
        F_T1:  if (mul_done) t1_r <= mul_prod;
        F_T2:  if (mul_done) t2_r <= mul_prod;
        F_DD:  if (mul_done) dd_r <= mul_prod;
        F_NUM: num_r <= u_r[UW-1] ? $signed(LW'(t1_r) + LW'(t2_r))
                                  : $signed(LW'(t1_r) - LW'(t2_r));
        F_N2:  n2_r <= (num_r <<< 1) + $signed(LW'(dd_r));
        F_ADJ: begin
          divd_r <= LW'(dd_r) << 1;
          neg_r  <= n2_r[LW-1];
          divn_r <= n2_r[LW-1] ? (LW'(dd_r) << 1) - LW'(1) - $unsigned(n2_r)
                               : $unsigned(n2_r);
        end
        F_DPL: ;
        F_LP:  if (mul_done) t1_r <= mul_prod;
        F_SPR: begin
          divn_r <= (LW'(t1_r) << 1) + LW'(f_q);
          divd_r <= LW'(f_q) << 1;
        end
        F_DSC: ;
        default: ;
      endcase
    end
  end

  // control, accumulators and box state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      fs_r        <= F_EM;
      axis_r      <= 1'b0;
      go_r        <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
      bl_r        <= '0;
      bt_r        <= '0;
      bw_r        <= '0;
      bh_r        <= '0;
      s1_v_r      <= 1'b0;
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      a_v_r  <= s1_v_r;
      b_v_r  <= a_v_r;
      c_v_r  <= b_v_r;
      if (issue) idx_r <= idx_r + 1'b1;
      if (mul_go || div_go) go_r <= 1'b1;
      else if (mul_done || div_done) go_r <= 1'b0;
      // a new result in S_OUT takes over the valid bit
      if (out_valid_r && !out_stall && st_r != S_OUT) out_valid_r <= 1'b0;

      unique case (st_r)
        S_IDLE: begin
          if (q_pop) begin
            if (q_cmd.kind == tbr_pkg::CMD_BOX) begin
              bl_r <= q_cmd.box_left;
              bt_r <= q_cmd.box_top;
              bw_r <= q_cmd.box_width;
              bh_r <= q_cmd.box_height;
            end else begin
              if (pt_we) cnt_r <= cnt_r + 1'b1;
              if (q_cmd.kind == tbr_pkg::CMD_CLOSE) begin
                st_r  <= S_P1;
                idx_r <= '0;
                sdx_r <= '0;
                sdy_r <= '0;
                sqx_r <= '0;
                sqy_r <= '0;
                sax_r <= '0;
                say_r <= '0;
                sbx_r <= '0;
                sby_r <= '0;
                pax_r <= '0;
                pay_r <= '0;
                pbx_r <= '0;
                pby_r <= '0;
                m_r   <= '0;
              end
            end
          end
        end
        // motion sums
        S_P1: begin
          if (b_v_r) begin
            sdx_r <= sdx_r + DSW'(b_dx_r);
            sdy_r <= sdy_r + DSW'(b_dy_r);
            sqx_r <= sqx_r + SQW'(b_sqx_r);
            sqy_r <= sqy_r + SQW'(b_sqy_r);
          end
          if (drained) st_r <= S_LIM1;
        end
        S_LIM1: begin
          nsx_r  <= VW'(cnt_r) * VW'(sqx_r);
          nsy_r  <= VW'(cnt_r) * VW'(sqy_r);
          sdsx_r <= sdsx_full[VW-1:0];
          sdsy_r <= sdsy_full[VW-1:0];
          nn_r   <= NNW'(cnt_r) * NNW'(cnt_r);
          st_r   <= S_LIM2;
        end
        S_LIM2: begin
          limx_r <= LIMW'(nsx_r - sdsx_r) << tbr_pkg::LIM_SHIFT;
          limy_r <= LIMW'(nsy_r - sdsy_r) << tbr_pkg::LIM_SHIFT;
          idx_r  <= '0;
          st_r   <= S_P2;
        end
        // outlier test and survivor sums
        S_P2: begin
          if (c_v_r && keep) begin
            m_r   <= m_r + 1'b1;
            sax_r <= sax_r + SW'(c_pt_r[63:48]);
            say_r <= say_r + SW'(c_pt_r[47:32]);
            sbx_r <= sbx_r + SW'(c_pt_r[31:16]);
            sby_r <= sby_r + SW'(c_pt_r[15:0]);
          end
          if (drained) begin
            idx_r <= '0;
            st_r  <= S_P3;
          end
        end
        // summed absolute spreads of the survivors about their mean
        S_P3: begin
          if (b_v_r && b_kp_r) begin
            pax_r <= pax_r + PW'(dbx);
            pay_r <= pay_r + PW'(dby);
            pbx_r <= pbx_r + PW'(dax);
            pby_r <= pby_r + PW'(day);
          end
          if (drained) st_r <= S_CHK;
        end
        S_CHK: begin
          degen_r <= (m_r == '0) || (pax_r == '0) || (pay_r == '0);
          axis_r  <= 1'b0;
          fs_r    <= F_EM;
          if ((m_r == '0) || (pax_r == '0) || (pay_r == '0)) st_r <= S_OUT;
          else st_r <= S_FIN;
        end
        // box update sequencer
        S_FIN: begin
          unique case (fs_r)
            F_EM:  fs_r <= F_U;
            F_U:   fs_r <= F_T1;
            F_T1:  if (mul_done) fs_r <= F_T2;
            F_T2:  if (mul_done) fs_r <= F_DD;
            F_DD:  if (mul_done) fs_r <= F_NUM;
            F_NUM: fs_r <= F_N2;
            F_N2:  fs_r <= F_ADJ;
            F_ADJ: fs_r <= F_DPL;
            F_DPL: begin
              if (div_done) begin
                if (axis_r) bt_r <= place_res;
                else bl_r <= place_res;
                fs_r <= F_LP;
              end
            end
            F_LP:  if (mul_done) fs_r <= F_SPR;
            F_SPR: fs_r <= F_DSC;
            F_DSC: begin
              if (div_done) begin
                if (axis_r) begin
                  bh_r <= scale_res;
                  st_r <= S_OUT;
                end else begin
                  bw_r   <= scale_res;
                  axis_r <= 1'b1;
                end
                fs_r <= F_EM;
              end
            end
            default: fs_r <= F_EM;
          endcase
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            cnt_r       <= '0;
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (st_r == S_OUT && out_free) begin
      out_data_r.new_left   <= bl_r;
      out_data_r.new_top    <= bt_r;
      out_data_r.new_width  <= bw_r;
      out_data_r.new_height <= bh_r;
      out_data_r.kept_count <= 9'(m_r);
      out_data_r.degenerate <= degen_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tbr_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tbr_pkg::out_t out_data;

  int errors = 0;
  bit stall_hold = 1'b0;
  tbr_pkg::out_t box_results_q[$];

  // predictor state
  logic [15:0] pred_bx[256];
  logic [15:0] pred_by[256];
  logic [15:0] pred_ax[256];
  logic [15:0] pred_ay[256];
  int unsigned pred_count = 0;
  logic signed [11:0] pred_left = '0;
  logic signed [11:0] pred_top = '0;
  logic [10:0] pred_width = '0;
  logic [10:0] pred_height = '0;

  track_box_rescale dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // round-half-up of num/den with den > 0, saturated
  function automatic longint round_sat(logic signed [191:0] num, logic signed [191:0] den,
                                       longint lo, longint hi);
    logic signed [191:0] n2;
    logic signed [191:0] q;
    n2 = 2 * num + den;
    q = n2 / (2 * den);
    if (q * 2 * den > n2) q = q - 1;
    if (q > hi) return hi;
    if (q < lo) return lo;
    return longint'(q);
  endfunction

  // motion filter and box update for the frame just closed
  function automatic tbr_pkg::out_t rescale_frame();
    tbr_pkg::out_t r;
    longint n, m, sdx, sdy, sqx, sqy, dx, dy;
    longint sax, say, sbx, sby, pax, pay, pbx, pby;
    logic signed [191:0] limx, limy;
    bit keep[256];
    n = pred_count; m = 0;
    sdx = 0; sdy = 0; sqx = 0; sqy = 0;
    sax = 0; say = 0; sbx = 0; sby = 0; pax = 0; pay = 0; pbx = 0; pby = 0;
    for (int i = 0; i < n; i++) begin
      dx = longint'(pred_ax[i]) - longint'(pred_bx[i]);
      dy = longint'(pred_ay[i]) - longint'(pred_by[i]);
      sdx += dx; sdy += dy; sqx += dx * dx; sqy += dy * dy;
    end
    limx = 64 * (192'(n) * sqx - 192'(sdx) * sdx);
    limy = 64 * (192'(n) * sqy - 192'(sdy) * sdy);
    for (int i = 0; i < n; i++) begin
      dx = longint'(pred_ax[i]) - longint'(pred_bx[i]);
      dy = longint'(pred_ay[i]) - longint'(pred_by[i]);
      keep[i] = !(192'(dx * dx) * n * n > limx) && !(192'(dy * dy) * n * n > limy);
      if (keep[i]) begin
        m++;
        sax += pred_bx[i]; say += pred_by[i]; sbx += pred_ax[i]; sby += pred_ay[i];
      end
    end
    for (int i = 0; i < n; i++) begin
      if (keep[i]) begin
        pax += (sax > m * pred_bx[i]) ? sax - m * pred_bx[i] : m * pred_bx[i] - sax;
        pay += (say > m * pred_by[i]) ? say - m * pred_by[i] : m * pred_by[i] - say;
        pbx += (sbx > m * pred_ax[i]) ? sbx - m * pred_ax[i] : m * pred_ax[i] - sbx;
        pby += (sby > m * pred_ay[i]) ? sby - m * pred_ay[i] : m * pred_ay[i] - sby;
      end
    end
    r.degenerate = (m == 0 || pax == 0 || pay == 0);
    if (!r.degenerate) begin
      // left = (sb*q - (sa - edge*m*64)*p) / (m*64*q)
      pred_left = 12'(round_sat(192'(sbx) * pax - (192'(sax) - 192'(pred_left) * m * 64) * pbx,
                                192'(m) * 64 * pax, -2048, 2047));
      pred_top = 12'(round_sat(192'(sby) * pay - (192'(say) - 192'(pred_top) * m * 64) * pby,
                               192'(m) * 64 * pay, -2048, 2047));
      pred_width = 11'(round_sat(192'(pred_width) * pbx, 192'(pax), 0, 2047));
      pred_height = 11'(round_sat(192'(pred_height) * pby, 192'(pay), 0, 2047));
    end
    r.new_left = pred_left; r.new_top = pred_top;
    r.new_width = pred_width; r.new_height = pred_height;
    r.kept_count = 9'(m);
    pred_count = 0;
    return r;
  endfunction

  function automatic void predict_request(tbr_pkg::in_t req);
    if (req.opcode == tbr_pkg::OP_BOX) begin
      pred_left = req.box_left; pred_top = req.box_top;
      pred_width = req.box_width; pred_height = req.box_height;
      return;
    end
    if (pred_count < 256) begin
      pred_bx[pred_count] = req.before_x; pred_by[pred_count] = req.before_y;
      pred_ax[pred_count] = req.after_x; pred_ay[pred_count] = req.after_y;
      pred_count++;
    end
    if (req.last_pair) box_results_q.push_back(rescale_frame());
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // send one request and update the prediction on acceptance
  task automatic send_request(tbr_pkg::in_t req);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(req);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (box_results_q.size() != 0) @(negedge clk);
  endtask

  function automatic tbr_pkg::in_t box_req(int l, int t, int w, int h);
    tbr_pkg::in_t r;
    r = '0;
    r.opcode = tbr_pkg::OP_BOX;
    r.box_left = 12'(l); r.box_top = 12'(t); r.box_width = 11'(w); r.box_height = 11'(h);
    r.before_x = 16'($urandom); r.after_y = 16'($urandom); r.last_pair = 1'($urandom);
    return r;
  endfunction

  function automatic tbr_pkg::in_t pair_req(int bx, int by, int ax, int ay, bit last);
    tbr_pkg::in_t r;
    r.opcode = tbr_pkg::OP_PAIR;
    r.box_left = 12'($urandom); r.box_top = 12'($urandom);
    r.box_width = 11'($urandom); r.box_height = 11'($urandom);
    r.before_x = 16'(bx); r.before_y = 16'(by); r.after_x = 16'(ax); r.after_y = 16'(ay);
    r.last_pair = last;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    tbr_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (box_results_q.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        want = box_results_q.pop_front();
        if (out_data.new_left !== want.new_left)
          report("new_left", out_data.new_left, want.new_left);
        if (out_data.new_top !== want.new_top)
          report("new_top", out_data.new_top, want.new_top);
        if (out_data.new_width !== want.new_width)
          report("new_width", out_data.new_width, want.new_width);
        if (out_data.new_height !== want.new_height)
          report("new_height", out_data.new_height, want.new_height);
        if (out_data.kept_count !== want.kept_count)
          report("kept_count", out_data.kept_count, want.kept_count);
        if (out_data.degenerate !== want.degenerate)
          report("degenerate", out_data.degenerate, want.degenerate);
      end
    end
  end

  // receiver stall pattern, with calm stretches
  always @(negedge clk) begin
    if (stall_hold) out_stall <= 1'b0;
    else if ($urandom_range(0, 9) == 0) out_stall <= 1'b1;
    else if ($urandom_range(0, 2) == 0) out_stall <= 1'b0;
  end

  task automatic test_extremes();
    send_request(box_req(-2048, 2047, 2047, 0));
    send_request(pair_req(0, 0, 0, 0, 1'b1));          // spread zero
    send_request(pair_req(0, 0, 0, 0, 1'b0));
    send_request(pair_req(65535, 65535, 65535, 65535, 1'b1));
    send_request(box_req(2047, -2048, 0, 2047));
    send_request(pair_req(0, 0, 65535, 65535, 1'b0));
    send_request(pair_req(65535, 65535, 0, 0, 1'b1));
    send_request(box_req(100, 100, 2047, 2047));
    send_request(pair_req(100, 100, 65535, 65535, 1'b0));
    send_request(pair_req(200, 200, 0, 0, 1'b1));      // scaling saturates
    send_request(box_req(5, 5, 50, 50));
    send_request(pair_req(1000, 1000, 1100, 1100, 1'b0));
    send_request(pair_req(2000, 2000, 2100, 2100, 1'b1));
    send_request(pair_req(1000, 2000, 1500, 1500, 1'b0));
    send_request(pair_req(3000, 4000, 1500, 1500, 1'b1)); // zero after-spread
    drain();
  endtask

  task automatic test_empty_frame();
    send_request(box_req(7, -7, 9, 9));
    // a full store then the closing pair, which is dropped
    for (int i = 0; i < 256; i++)
      send_request(pair_req(6400 + i * 8, 6400 + (i % 9) * 16,
                            6464 + i * 9, 6500 + (i % 7) * 20, 1'b0));
    send_request(pair_req(65535, 65535, 0, 0, 1'b1));
    drain();
  endtask

  task automatic test_outlier();
    send_request(box_req(300, 200, 120, 80));
    for (int i = 0; i < 80; i++)
      send_request(pair_req(10000 + i * 64, 12000 + i * 32, 10064 + i * 64 + (i % 3),
                            12032 + i * 32 - (i % 2), 1'b0));
    send_request(pair_req(5000, 5000, 60000, 60000, 1'b1));
    drain();
  endtask

  task automatic test_random();
    int frames;
    int len;
    int cx, cy, mx, my, sc;
    frames = 0;
    for (int sent = 0; sent < 690;) begin
      if ($urandom_range(0, 3) == 0) begin
        send_request(box_req($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                             $urandom_range(0, 2047), $urandom_range(0, 2047)));
        sent++;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 24);
      cx = $urandom_range(2000, 60000); cy = $urandom_range(2000, 60000);
      mx = $urandom_range(0, 800) - 400; my = $urandom_range(0, 800) - 400;
      sc = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) begin
        int bx, by, ax, ay;
        bx = cx + $urandom_range(0, 3000) - 1500;
        by = cy + $urandom_range(0, 3000) - 1500;
        ax = cx + mx + ((bx - cx) * (sc + 2)) / 4 + int'($urandom_range(0, 20));
        ay = cy + my + ((by - cy) * (sc + 2)) / 4 + int'($urandom_range(0, 20));
        if ($urandom_range(0, 7) == 0) begin
          bx = $urandom; by = $urandom; ax = $urandom; ay = $urandom;
        end
        send_request(pair_req(bx & 16'hffff, by & 16'hffff, ax & 16'hffff, ay & 16'hffff,
                              i == len - 1));
        sent++;
      end
      if (len == 0) begin
        send_request(pair_req($urandom, $urandom, $urandom, $urandom, 1'b1));
        sent++;
      end
      frames++;
      if (frames % 10 == 0) begin
        stall_hold = ($urandom_range(0, 1) == 0);
      end
    end
    stall_hold = 1'b0;
    drain();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_extremes();
    test_empty_frame();
    test_outlier();
    test_random();
    repeat (1500) @(negedge clk);
    if (errors == 0 && box_results_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== track_box_rescale.f =====
design/tbr_pkg.sv
design/tbr_front.sv
design/tbr_mul.sv
design/tbr_div.sv
design/tbr_back.sv
design/track_box_rescale.sv
bench/tb.sv
